// File: rtl/hsfc_pkg.sv
// Package: constants and conversion functions for the half/single converter.
`default_nettype none
package hsfc_pkg;
   localparam int unsigned ACTION_W = 1;
   localparam int unsigned VALUE_W = 32;
   localparam int unsigned REQ_TDATA_W = 40;
   localparam logic ACT_H2S = 1'b0;
   localparam logic ACT_S2H = 1'b1;
   localparam logic [31:0] F32_SMALLEST_HALF_NORMAL = 32'(113) << 23;
   localparam logic [31:0] F32_HALF_OVERFLOW = 32'(143) << 23;
   localparam logic [31:0] F32_INF_BITS = 32'(255) << 23;
   localparam logic [15:0] H_EXP_MASK = 16'h7c00;
   localparam logic [15:0] H_CANON_NAN = 16'h7e00;
   localparam logic [31:0] ROUND_BIAS = 32'h0000_0fff;
   localparam logic [31:0] F32_SIGN = 32'h8000_0000;
   localparam logic [15:0] H_SIGN = 16'h8000;

   function automatic logic [31:0] half_to_single(input logic [15:0] h);
      logic [31:0] r;
      logic [9:0] man;
      logic [3:0] p;
      logic [9:0] sh;
      man = h[9:0];
      p = 4'd0;
      sh = '0;
      if ((h & H_EXP_MASK) == H_EXP_MASK) begin
         r = F32_INF_BITS | {9'd0, man, 13'd0};
      end else if ((h & H_EXP_MASK) != 16'd0) begin
         r = {4'b0000, h[14:0], 13'd0} + (32'(112) << 23);
      end else if (man == 10'd0) begin
         r = '0;
      end else begin
         for (int i = 0; i < 10; i++) begin
            if (man[i]) p = 4'(i);
         end
         sh = man << (4'd10 - p);
         r = {1'b0, 8'(8'd103 + {4'd0, p}), sh, 13'd0};
      end
      return r | {h[15], 31'd0};
   endfunction

   function automatic logic [15:0] single_to_half(input logic [31:0] x);
      logic [31:0] a;
      logic [31:0] t;
      logic [15:0] o;
      logic [23:0] m;
      logic [4:0] s;
      logic [23:0] q;
      logic [23:0] rem;
      logic [23:0] hlf;
      a = x & ~F32_SIGN;
      o = '0;
      t = '0;
      m = {1'b1, a[22:0]};
      s = '0;
      q = '0;
      rem = '0;
      hlf = '0;
      if (a >= F32_HALF_OVERFLOW) begin
         o = (a > F32_INF_BITS) ? H_CANON_NAN : H_EXP_MASK;
      end else if (a < F32_SMALLEST_HALF_NORMAL) begin
         // exponent 0..112: shift 14..126, nonzero only when shift <= 24
         if (a[30:23] != 8'd0 && a[30:23] >= 8'd102) begin
            s = 5'(8'd126 - a[30:23]);
            q = m >> s;
            hlf = 24'd1 << (s - 5'd1);
            rem = m & ((hlf << 1) - 24'd1);
            if (rem > hlf || (rem == hlf && q[0])) q = q + 24'd1;
            o = q[15:0];
         end
      end else begin
         t = a - (32'(112) << 23) + ROUND_BIAS + {31'd0, a[13]};
         o = t[28:13];
      end
      return o | (x[31] ? H_SIGN : 16'd0);
   endfunction
endpackage
`default_nettype wire

// File: rtl/half_single_float_converter_unit.sv
// Top level: binary16 <-> binary32 converter with registered input and output.
// Channel | Direction | tdata
// req_    | in        | [0] action, [32:1] value_in, [39:33] zero
// rsp_    | out       | [31:0] value_out
// One transaction per cycle unless stalled; registers: input, then result.
// The conversion logic between the two registers sets the cycle.
// reset clears valid flags only; payload registers are not reset.
// Full output, rsp_tready low: both stall; req_tready drops only when both full.
`default_nettype none
module half_single_float_converter_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // action, value_in
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata    // value_out
);
   logic        in_vld_ff, in_vld_in;
   logic        in_act_ff;
   logic [31:0] in_val_ff;
   logic        out_vld_ff, out_vld_in;
   logic [31:0] out_val_ff, out_val_in;
   logic        adv;

   assign adv = !out_vld_ff || rsp_tready;
   assign req_tready = !in_vld_ff || adv;
   assign out_vld_in = adv ? in_vld_ff : out_vld_ff;
   assign in_vld_in = req_tready ? req_tvalid : in_vld_ff;
   assign out_val_in = (in_act_ff == hsfc_pkg::ACT_S2H)
      ? {16'd0, hsfc_pkg::single_to_half(in_val_ff)}
      : hsfc_pkg::half_to_single(in_val_ff[15:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
      if (req_tready && req_tvalid) begin
         in_act_ff <= req_tdata[0];
         in_val_ff <= req_tdata[32:1];
      end
      if (adv && in_vld_ff) out_val_ff <= out_val_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata = out_val_ff;
endmodule
`default_nettype wire

// File: rtl/hsfc_checker.sv
// Checker: port-level assertions for the converter, bound to the top level.
`default_nettype none
module hsfc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp changed under stall");
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req stalled with empty output");
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && rsp_tready ##1 rsp_tready |=> rsp_tvalid)
      else $error("result missing after two cycles");
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");
endmodule

bind half_single_float_converter_unit hsfc_checker u_hsfc_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata));
`default_nettype wire
